// ===== design/ps2ht_pkg.sv =====
// Package for the PS/2 host byte transceiver: field widths, command codes,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package ps2ht_pkg;

  localparam int KindW  = 2;
  localparam int ByteW  = 8;
  localparam int DelayW = 16;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 1;

  // Command codes carried in the kind field
  localparam logic [KindW-1:0] KIND_TICK = 2'd0;
  localparam logic [KindW-1:0] KIND_SEND = 2'd1;
  localparam logic [KindW-1:0] KIND_RECV = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_INHIBIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE = 1'b1;

  localparam logic [DelayW-1:0] INHIBIT_RESET = 16'd100;
  localparam logic [DelayW-1:0] RELEASE_RESET = 16'd50;

  localparam int DATA_BITS_DEFAULT = 8;

endpackage

// ===== design/ps2ht_if.sv =====
// Valid/ready channel interfaces for the PS/2 host transceiver: line-sample
// words in, drive/status words out. Depends on ps2ht_pkg.
`timescale 1ns / 1ps

interface ps2ht_in_if;
  logic                         valid;
  logic                         ready;
  logic [ps2ht_pkg::KindW-1:0]  kind;
  logic                         clock_line;
  logic                         data_line;
  logic [ps2ht_pkg::ByteW-1:0]  byte_in;

  modport source (output valid, kind, clock_line, data_line, byte_in, input ready);
  modport sink   (input valid, kind, clock_line, data_line, byte_in, output ready);
endinterface

interface ps2ht_out_if;
  logic                         valid;
  logic                         ready;
  logic                         clock_drive_low;
  logic                         data_drive_low;
  logic                         busy_res;
  logic                         done_res;
  logic [ps2ht_pkg::ByteW-1:0]  byte_out;

  modport source (output valid, clock_drive_low, data_drive_low, busy_res, done_res,
                  byte_out, input ready);
  modport sink   (input valid, clock_drive_low, data_drive_low, busy_res, done_res,
                  byte_out, output ready);
endinterface

// ===== design/ps2_host_byte_transceiver_core.sv =====
// PS/2 host transceiver top level: one sampling tick per input word, one
// drive/status word out per tick. Depends on ps2ht_pkg and ps2ht_if.
// Latency: an accepted word gives its result word in the output register on the
// next cycle. Throughput: one word per cycle; the only stall is a full output
// register whose word is not taken (ready follows that register and out ready).
// Reset (rst_ni low, asynchronous): idle, clock and data released, delays 100/50.
`timescale 1ns / 1ps

module ps2_host_byte_transceiver_core #(
  parameter int DATA_BITS = ps2ht_pkg::DATA_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ps2ht_in_if.sink                      in_s,
  ps2ht_out_if.source                   out_m,
  input  logic                          cfg_we_i,
  input  logic [ps2ht_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ps2ht_pkg::CfgW-1:0]    cfg_data_i
);

  // Bit counter must hold DATA_BITS itself
  localparam int BitCntW = $clog2(DATA_BITS + 1);
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(DATA_BITS);

  // Transfer phases: send path (inhibit, data bits, parity, stop, ack) then the
  // receive path, which a send falls into for the reply byte.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_INHIBIT,
    PH_TX_BITS,
    PH_TX_PARITY,
    PH_TX_STOP,
    PH_TX_ACK,
    PH_RX_START,
    PH_RX_BITS,
    PH_RX_PARITY,
    PH_RX_STOP,
    PH_RX_RELEASE
  } phase_e;

  // Configuration registers
  logic [ps2ht_pkg::DelayW-1:0] inhibit_ticks_q, release_ticks_q;

  // Transfer state
  phase_e                       phase_q, phase_d;
  logic [BitCntW-1:0]           bit_cnt_q, bit_cnt_d;
  logic [ps2ht_pkg::ByteW-1:0]  shift_q, shift_d;
  logic                         parity_q, parity_d;
  logic [ps2ht_pkg::DelayW-1:0] delay_q, delay_d;
  logic                         last_clk_q;
  logic                         hold_clk_q, hold_clk_d;
  logic                         data_low_q, data_low_d;

  // Output register
  logic                         out_valid_q;
  logic                         out_clk_low_q, out_data_low_q, out_busy_q, out_done_q;
  logic [ps2ht_pkg::ByteW-1:0]  out_byte_q;

  logic                         done_d;
  logic [ps2ht_pkg::ByteW-1:0]  result_d;
  logic                         fall;
  logic                         in_acc;
  logic [BitCntW-1:0]           bit_cnt_inc;

  // Take a new word whenever the output register is empty or drains this cycle
  assign in_s.ready = !out_valid_q || out_m.ready;
  assign in_acc     = in_s.valid && in_s.ready;

  // Device clock falling edge, seen against the previous tick's sample
  assign fall        = last_clk_q && !in_s.clock_line;
  assign bit_cnt_inc = bit_cnt_q + BitCntW'(1);

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    parity_d   = parity_q;
    delay_d    = delay_q;
    hold_clk_d = hold_clk_q;
    data_low_d = data_low_q;
    done_d     = 1'b0;
    result_d   = '0;

    if (phase_q == PH_IDLE && in_s.kind == ps2ht_pkg::KIND_SEND) begin
      // Start a send: hold clock low for the inhibit time
      shift_d    = in_s.byte_in;
      parity_d   = 1'b1;
      bit_cnt_d  = '0;
      hold_clk_d = 1'b1;
      data_low_d = 1'b0;
      delay_d    = inhibit_ticks_q;
      phase_d    = PH_INHIBIT;
    end else if (phase_q == PH_IDLE && in_s.kind == ps2ht_pkg::KIND_RECV) begin
      hold_clk_d = 1'b0;
      data_low_d = 1'b0;
      shift_d    = '0;
      bit_cnt_d  = '0;
      phase_d    = PH_RX_START;
    end else begin
      case (phase_q)
        PH_INHIBIT: begin
          // Zero counts as one tick; on expiry drive the start bit, release clock
          if (delay_q <= ps2ht_pkg::DelayW'(1)) begin
            delay_d    = '0;
            data_low_d = 1'b1;
            hold_clk_d = 1'b0;
            phase_d    = PH_TX_BITS;
          end else begin
            delay_d = delay_q - ps2ht_pkg::DelayW'(1);
          end
        end
        PH_TX_BITS: begin
          if (fall) begin
            // Drive LSB; bits past the eighth shift out as zero
            data_low_d = !shift_q[0];
            parity_d   = parity_q ^ shift_q[0];
            shift_d    = shift_q >> 1;
            bit_cnt_d  = bit_cnt_inc;
            if (bit_cnt_inc >= LastBit) phase_d = PH_TX_PARITY;
          end
        end
        PH_TX_PARITY: begin
          if (fall) begin
            data_low_d = !parity_q;
            phase_d    = PH_TX_STOP;
          end
        end
        PH_TX_STOP: begin
          if (fall) begin
            data_low_d = 1'b0;
            phase_d    = PH_TX_ACK;
          end
        end
        PH_TX_ACK: begin
          // Acknowledge clock passes; fall into receiving the reply byte
          if (fall) begin
            hold_clk_d = 1'b0;
            data_low_d = 1'b0;
            shift_d    = '0;
            bit_cnt_d  = '0;
            phase_d    = PH_RX_START;
          end
        end
        PH_RX_START: begin
          if (fall) phase_d = PH_RX_BITS;
        end
        PH_RX_BITS: begin
          if (fall) begin
            // Drop received bits past the eighth
            if (32'(bit_cnt_q) < ps2ht_pkg::ByteW) begin
              shift_d[bit_cnt_q[2:0]] = shift_q[bit_cnt_q[2:0]] | in_s.data_line;
            end
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= LastBit) phase_d = PH_RX_PARITY;
          end
        end
        PH_RX_PARITY: begin
          if (fall) phase_d = PH_RX_STOP;
        end
        PH_RX_STOP: begin
          if (fall) begin
            hold_clk_d = 1'b1;
            delay_d    = release_ticks_q;
            phase_d    = PH_RX_RELEASE;
          end
        end
        PH_RX_RELEASE: begin
          // Clock stays held low (inhibit) after the byte is reported
          if (delay_q <= ps2ht_pkg::DelayW'(1)) begin
            delay_d  = '0;
            done_d   = 1'b1;
            result_d = shift_q;
            phase_d  = PH_IDLE;
          end else begin
            delay_d = delay_q - ps2ht_pkg::DelayW'(1);
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inhibit_ticks_q <= ps2ht_pkg::INHIBIT_RESET;
      release_ticks_q <= ps2ht_pkg::RELEASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ps2ht_pkg::CFG_INHIBIT: inhibit_ticks_q <= cfg_data_i;
        ps2ht_pkg::CFG_RELEASE: release_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the transfer state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      parity_q   <= 1'b1;
      delay_q    <= '0;
      last_clk_q <= 1'b1;
      hold_clk_q <= 1'b0;
      data_low_q <= 1'b0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      parity_q   <= parity_d;
      delay_q    <= delay_d;
      last_clk_q <= in_s.clock_line;
      hold_clk_q <= hold_clk_d;
      data_low_q <= data_low_d;
    end
  end

  // Output register: hold a word until taken, load a new one on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_clk_low_q  <= hold_clk_d;
      out_data_low_q <= data_low_d;
      out_busy_q     <= (phase_d != PH_IDLE);
      out_done_q     <= done_d;
      out_byte_q     <= result_d;
    end
  end

  assign out_m.valid           = out_valid_q;
  assign out_m.clock_drive_low = out_clk_low_q;
  assign out_m.data_drive_low  = out_data_low_q;
  assign out_m.busy_res        = out_busy_q;
  assign out_m.done_res        = out_done_q;
  assign out_m.byte_out        = out_byte_q;

  // An accepted word always shows up in the output register next cycle
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted word did not reach the output register");

  // A finishing transfer is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> !out_busy_q)
    else $error("done word reported busy");

  // Byte field is zero except on a done word
  a_byte_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_done_q) |-> (out_byte_q == '0))
    else $error("byte reported without done");

  // Data line is released throughout the receive path
  a_rx_data_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RX_START || phase_q == PH_RX_BITS || phase_q == PH_RX_PARITY ||
     phase_q == PH_RX_STOP || phase_q == PH_RX_RELEASE) |-> !data_low_q)
    else $error("data driven low while receiving");

endmodule

// ===== tb/ps2_host_byte_transceiver_core_tb.sv =====
// Self-checking bench for the PS/2 host byte transceiver: drives line-sample words
// from a device clock model and checks every drive/status word against a predictor.
// Depends on ps2ht_pkg, ps2ht_if and the core; the scoreboard class lives here.
`timescale 1ns / 1ps

module ps2_host_byte_transceiver_core_tb;

  localparam int          FRAME_BITS     = ps2ht_pkg::DATA_BITS_DEFAULT;
  localparam int          RANDOM_WORDS   = 550;
  localparam int          WATCHDOG_LIMIT = 1000;
  // unused code, acts as a tick
  localparam logic [ps2ht_pkg::KindW-1:0] KIND_SPARE = 2'd3;

  // Transfer phases of the predictor
  typedef enum logic [3:0] {
    XF_IDLE, XF_HOLD_OFF, XF_TX_DATA, XF_TX_PAR, XF_TX_STOP, XF_TX_ACK,
    XF_RX_START, XF_RX_DATA, XF_RX_PAR, XF_RX_STOP, XF_RX_HOLD
  } xfer_phase_e;

  typedef struct packed {
    logic                        clk_low;
    logic                        dat_low;
    logic                        busy;
    logic                        done;
    logic [ps2ht_pkg::ByteW-1:0] rx_byte;
  } drive_word_t;

  // Line-level predictor plus the queue of drive words still owed by the core.
  class ps2_xfer_scoreboard;
    logic [ps2ht_pkg::DelayW-1:0] hold_off_len, rel_len;
    xfer_phase_e                  ph;
    logic [3:0]                   nbits;
    logic [ps2ht_pkg::ByteW-1:0]  shreg;
    logic                         par, prev_clk, clk_hold, dat_hold;
    logic [ps2ht_pkg::DelayW-1:0] dly;
    drive_word_t                  exp_drive_q[$];
    int                           errors;

    function void clear();
      hold_off_len = ps2ht_pkg::INHIBIT_RESET;
      rel_len      = ps2ht_pkg::RELEASE_RESET;
      ph           = XF_IDLE;
      nbits        = '0;
      shreg        = '0;
      par          = 1'b1;
      dly          = '0;
      prev_clk     = 1'b1;
      clk_hold     = 1'b0;
      dat_hold     = 1'b0;
      exp_drive_q.delete();
    endfunction

    function void start_rx();
      clk_hold = 1'b0;
      dat_hold = 1'b0;
      shreg    = '0;
      nbits    = '0;
      ph       = XF_RX_START;
    endfunction

    function drive_word_t next_drive_word(logic [ps2ht_pkg::KindW-1:0] kind, logic cl,
                                          logic dl, logic [ps2ht_pkg::ByteW-1:0] bi);
      logic        fall;
      drive_word_t w;
      fall = prev_clk && !cl;
      w    = '0;
      if (ph == XF_IDLE && kind == ps2ht_pkg::KIND_SEND) begin
        shreg    = bi;
        par      = 1'b1;
        nbits    = '0;
        clk_hold = 1'b1;
        dat_hold = 1'b0;
        dly      = hold_off_len;
        ph       = XF_HOLD_OFF;
      end else if (ph == XF_IDLE && kind == ps2ht_pkg::KIND_RECV) begin
        start_rx();
      end else begin
        case (ph)
          XF_HOLD_OFF: begin
            if (dly <= 1) begin
              dly      = '0;
              dat_hold = 1'b1;
              clk_hold = 1'b0;
              ph       = XF_TX_DATA;
            end else begin
              dly = dly - 1'b1;
            end
          end
          XF_TX_DATA: if (fall) begin
            dat_hold = ~shreg[0];
            par      = par ^ shreg[0];
            shreg    = shreg >> 1;
            nbits    = nbits + 1'b1;
            if (nbits >= FRAME_BITS) ph = XF_TX_PAR;
          end
          XF_TX_PAR: if (fall) begin
            dat_hold = ~par;
            ph       = XF_TX_STOP;
          end
          XF_TX_STOP: if (fall) begin
            dat_hold = 1'b0;
            ph       = XF_TX_ACK;
          end
          XF_TX_ACK:   if (fall) start_rx();
          XF_RX_START: if (fall) ph = XF_RX_DATA;
          XF_RX_DATA: if (fall) begin
            if (nbits < 8) shreg[nbits[2:0]] = shreg[nbits[2:0]] | dl;
            nbits = nbits + 1'b1;
            if (nbits >= FRAME_BITS) ph = XF_RX_PAR;
          end
          XF_RX_PAR: if (fall) ph = XF_RX_STOP;
          XF_RX_STOP: if (fall) begin
            clk_hold = 1'b1;
            dly      = rel_len;
            ph       = XF_RX_HOLD;
          end
          XF_RX_HOLD: begin
            if (dly <= 1) begin
              dly       = '0;
              w.done    = 1'b1;
              w.rx_byte = shreg;
              ph        = XF_IDLE;
            end else begin
              dly = dly - 1'b1;
            end
          end
          default: ph = XF_IDLE;
        endcase
      end
      prev_clk  = cl;
      w.clk_low = clk_hold;
      w.dat_low = dat_hold;
      w.busy    = (ph != XF_IDLE);
      return w;
    endfunction

    function void note_line_word(logic [ps2ht_pkg::KindW-1:0] kind, logic cl, logic dl,
                                 logic [ps2ht_pkg::ByteW-1:0] bi);
      exp_drive_q.push_back(next_drive_word(kind, cl, dl, bi));
    endfunction

    function void cmp_field(string name, logic [ps2ht_pkg::ByteW-1:0] exp_v,
                            logic [ps2ht_pkg::ByteW-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_drive_word(drive_word_t got);
      drive_word_t want;
      if (exp_drive_q.size() == 0) begin
        errors++;
        $display("%0t: drive word with none predicted, expected none, actual %p",
                 $time, got);
        return;
      end
      want = exp_drive_q.pop_front();
      cmp_field("clock_drive_low", want.clk_low, got.clk_low);
      cmp_field("data_drive_low", want.dat_low, got.dat_low);
      cmp_field("busy_res", want.busy, got.busy);
      cmp_field("done_res", want.done, got.done);
      cmp_field("byte_out", want.rx_byte, got.rx_byte);
    endfunction

    function int pending();
      return exp_drive_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                          cfg_we;
  logic [ps2ht_pkg::CfgIdxW-1:0] cfg_idx;
  logic [ps2ht_pkg::CfgW-1:0]    cfg_data;

  ps2ht_in_if  in_if ();
  ps2ht_out_if out_if ();

  ps2_host_byte_transceiver_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_if),
    .out_m     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  ps2_xfer_scoreboard sb = new();

  int          gap_pct;     // chance per word that the sender pauses
  int          stall_pct;   // chance per cycle that the receiver starts a stall
  int          stall_left;
  int          idle_cycles;
  int unsigned line_words;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Drop ready in bursts started at random; hold it high when stalls are off.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Check drive words before noting the word taken on the same edge, then run the
  // watchdog on cycles where neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_drive_word({out_if.clock_drive_low, out_if.data_drive_low,
                             out_if.busy_res, out_if.done_res, out_if.byte_out});
      if (in_if.valid && in_if.ready)
        sb.note_line_word(in_if.kind, in_if.clock_line, in_if.data_line, in_if.byte_in);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Present one line-sample word, starting and ending at a falling edge; pause
  // the sender first now and then.
  task automatic send_line_word(input logic [ps2ht_pkg::KindW-1:0] kind, input logic cl,
                                input logic dl, input logic [ps2ht_pkg::ByteW-1:0] bi);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= kind;
    in_if.clock_line <= cl;
    in_if.data_line  <= dl;
    in_if.byte_in    <= bi;
    do @(posedge clk_i); while (!in_if.ready);
    line_words++;
    @(negedge clk_i);
  endtask

  // One tick of the device: the clock line is the wired AND of the device clock
  // and the host pull-down; data carries the reply bit while the host samples.
  task automatic device_tick(input logic dev_clk, input logic [ps2ht_pkg::ByteW-1:0] reply,
                             input int glitch_pct);
    logic [ps2ht_pkg::KindW-1:0] kind;
    logic                        cl, dl;
    kind = ps2ht_pkg::KIND_TICK;
    cl   = dev_clk & ~sb.clk_hold;
    if (sb.ph == XF_RX_DATA) dl = reply[sb.nbits[2:0]];
    else                     dl = sb.dat_hold ? 1'b0 : 1'($urandom_range(0, 1));
    // Inject a command while busy, a spare code or a clock glitch
    if (glitch_pct != 0 && $urandom_range(99) < glitch_pct) begin
      kind = ps2ht_pkg::KindW'($urandom_range(1, 3));
      cl   = 1'($urandom_range(0, 1));
    end
    send_line_word(kind, cl, dl, ps2ht_pkg::ByteW'($urandom_range(0, 255)));
  endtask

  // Issue a command (none for a tick) and clock the device until the transfer ends.
  task automatic run_transfer(input logic [ps2ht_pkg::KindW-1:0] cmd, input logic cmd_clk,
                              input logic [ps2ht_pkg::ByteW-1:0] tx_byte,
                              input logic [ps2ht_pkg::ByteW-1:0] reply,
                              input int glitch_pct);
    int hi, lo;
    if (cmd != ps2ht_pkg::KIND_TICK)
      send_line_word(cmd, cmd_clk, 1'($urandom_range(0, 1)), tx_byte);
    while (sb.ph != XF_IDLE) begin
      hi = $urandom_range(1, 3);
      lo = $urandom_range(1, 3);
      repeat (hi) if (sb.ph != XF_IDLE) device_tick(1'b1, reply, glitch_pct);
      repeat (lo) if (sb.ph != XF_IDLE) device_tick(1'b0, reply, glitch_pct);
    end
  endtask

  task automatic noise_burst(input int n);
    repeat (n) send_line_word(ps2ht_pkg::KindW'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              ps2ht_pkg::ByteW'($urandom_range(0, 255)));
  endtask

  // Drop valid and hold until every owed drive word has been taken.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic load_delays(input logic [ps2ht_pkg::CfgW-1:0] inh,
                             input logic [ps2ht_pkg::CfgW-1:0] rel);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= ps2ht_pkg::CFG_INHIBIT;
    cfg_data <= inh;
    @(negedge clk_i);
    cfg_idx  <= ps2ht_pkg::CFG_RELEASE;
    cfg_data <= rel;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    sb.hold_off_len = inh;
    sb.rel_len      = rel;
  endtask

  function automatic logic [ps2ht_pkg::CfgW-1:0] pick_delay();
    case ($urandom_range(3))
      0:       return 16'd1;
      1:       return ps2ht_pkg::CfgW'($urandom_range(1, 4));
      2:       return ps2ht_pkg::CfgW'($urandom_range(5, 40));
      default: return ps2ht_pkg::CfgW'($urandom_range(41, 120));
    endcase
  endfunction

  initial begin
    int unsigned base;
    int          phase_no;
    int          pick;
    in_if.valid      = 1'b0;
    in_if.kind       = ps2ht_pkg::KIND_TICK;
    in_if.clock_line = 1'b1;
    in_if.data_line  = 1'b1;
    in_if.byte_in    = '0;
    out_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = ps2ht_pkg::CFG_INHIBIT;
    cfg_data         = '0;
    rst_ni           = 1'b0;
    gap_pct          = 0;
    stall_pct        = 0;
    stall_left       = 0;
    idle_cycles      = 0;
    line_words       = 0;
    phase_no         = 0;
    sb.clear();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset delays: spare code at idle, then a send whose command
    // word lands on a falling clock edge, with commands injected while busy, then a receive
    gap_pct   = 10;
    stall_pct = 10;
    send_line_word(KIND_SPARE, 1'b1, 1'b1, 8'h00);
    send_line_word(ps2ht_pkg::KIND_TICK, 1'b0, 1'b0, 8'hFF);
    send_line_word(ps2ht_pkg::KIND_TICK, 1'b1, 1'b1, 8'h00);
    run_transfer(ps2ht_pkg::KIND_SEND, 1'b0, 8'h00, 8'hFF, 10);
    run_transfer(ps2ht_pkg::KIND_RECV, 1'b1, 8'h00, 8'h00, 0);
    // Shortest delays, then zero, which must behave as one tick
    load_delays(16'd1, 16'd1);
    run_transfer(ps2ht_pkg::KIND_SEND, 1'b1, 8'hFF, 8'h5A, 0);
    run_transfer(ps2ht_pkg::KIND_RECV, 1'b0, 8'h00, 8'hFF, 0);
    load_delays(16'd0, 16'd0);
    run_transfer(ps2ht_pkg::KIND_SEND, 1'b1, 8'h96, 8'h01, 0);
    run_transfer(ps2ht_pkg::KIND_RECV, 1'b1, 8'h00, 8'h80, 0);

    // Random part: mostly complete transfers with random bytes and delays, some
    // raw noise that is then clocked out to idle
    base = line_words;
    while (line_words - base < RANDOM_WORDS) begin
      phase_no++;
      case (phase_no % 3)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 8;  stall_pct = 8;  end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      load_delays(pick_delay(), pick_delay());
      repeat (4) begin
        pick = $urandom_range(9);
        if (pick < 7) begin
          run_transfer(pick[0] ? ps2ht_pkg::KIND_SEND : ps2ht_pkg::KIND_RECV,
                       1'($urandom_range(0, 1)),
                       ps2ht_pkg::ByteW'($urandom_range(0, 255)),
                       ps2ht_pkg::ByteW'($urandom_range(0, 255)),
                       (pick == 0) ? 5 : 0);
        end else begin
          noise_burst($urandom_range(1, 20));
          run_transfer(ps2ht_pkg::KIND_TICK, 1'b1, 8'h00,
                       ps2ht_pkg::ByteW'($urandom_range(0, 255)), 0);
        end
      end
    end

    // Last part, no idling: long hold-off and release in one send and reply
    gap_pct   = 0;
    stall_pct = 0;
    load_delays(16'd120, 16'd120);
    run_transfer(ps2ht_pkg::KIND_SEND, 1'b1, ps2ht_pkg::ByteW'($urandom_range(0, 255)),
                 ps2ht_pkg::ByteW'($urandom_range(0, 255)), 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
